// ===== design/poi_pkg.sv =====
// Shared constants, types and helpers of the periodic orbit interpolator.
package poi_pkg;

  localparam int unsigned POINTS_DEF = 64;
  localparam int unsigned CW = 48;        // coordinate width
  localparam int unsigned TW = 62;        // time width
  localparam int unsigned TDATA_IN_W = 264;
  localparam int unsigned TDATA_OUT_W = 96;
  localparam int unsigned ADDR_W = 5;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] REG_HAS_PARENT = 5'd0;
  localparam logic [ADDR_W-1:0] REG_PERIOD     = 5'd8;
  localparam logic [ADDR_W-1:0] REG_SEGMENT    = 5'd16;
  localparam logic [ADDR_W-1:0] REG_OFFSET     = 5'd24;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// ===== design/periodic_orbit_interpolator_top.sv =====
// Top level of the periodic orbit interpolator: table RAMs, divider pipeline and output stage.
//
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tdata, tuser = req_type
//  m_axis  | out | tvalid/tready      | tdata = pos_x, pos_y
//  apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// One item is accepted every cycle while the pipeline advances. A query passes through 64
// modulo stages, 63 segment divide stages, four stages for table read, differences and
// products, and 113 product divide stages before it reaches the output register. A write item
// travels down the same pipe and reaches the table at the end of stage B. The whole pipeline
// stalls while the output register holds an untaken result. Reset clears the valid bits,
// has_parent and offset, sets period and segment to 1; table RAMs are undefined until written.
module periodic_orbit_interpolator_top #(
  parameter int unsigned POINTS = poi_pkg::POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: point_index[5:0], point_x[53:6], point_y[101:54], query_time[163:102],
  //        parent_x[211:164], parent_y[259:212] -> packed to 264 bits
  input  logic [poi_pkg::TDATA_IN_W-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: pos_x[47:0], pos_y[95:48]
  output logic [poi_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [poi_pkg::ADDR_W-1:0]     paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned CW = poi_pkg::CW;
  localparam int unsigned TW = poi_pkg::TW;
  localparam int unsigned IW = $clog2(POINTS);
  localparam int unsigned PW = 112;   // product width for a 49 x 62 bit product

  // Configuration registers.
  logic          has_parent;
  logic [TW-1:0] orbit_period, segment_time, clock_offset;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_parent   <= 1'b0;
      orbit_period <= TW'(1);
      segment_time <= TW'(1);
      clock_offset <= '0;
    end else if (cfg_wr) begin
      case (paddr)
        poi_pkg::REG_HAS_PARENT: has_parent   <= pwdata[0];
        poi_pkg::REG_PERIOD:     orbit_period <= pwdata[TW-1:0];
        poi_pkg::REG_SEGMENT:    segment_time <= pwdata[TW-1:0];
        poi_pkg::REG_OFFSET:     clock_offset <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      poi_pkg::REG_HAS_PARENT: prdata = {63'd0, has_parent};
      poi_pkg::REG_PERIOD:     prdata = {2'd0, orbit_period};
      poi_pkg::REG_SEGMENT:    prdata = {2'd0, segment_time};
      poi_pkg::REG_OFFSET:     prdata = {2'd0, clock_offset};
      default:                 prdata = '0;
    endcase
  end

  logic [TW-1:0] per, seg;
  assign per = (orbit_period == '0) ? TW'(1) : orbit_period;
  assign seg = (segment_time == '0) ? TW'(1) : segment_time;

  // Global advance: the pipeline moves unless a held result blocks it.
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic          in_fire, in_query, in_write;
  logic [5:0]    in_index;
  logic [CW-1:0] in_px, in_py, in_parx, in_pary;
  logic [TW-1:0] in_time;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_query = in_fire && (s_axis_tuser == poi_pkg::REQ_QUERY);
  assign in_write = in_fire && (s_axis_tuser == poi_pkg::REQ_WRITE)
                    && ({26'd0, in_index} < 32'(POINTS));
  assign in_index = s_axis_tdata[5:0];
  assign in_px    = s_axis_tdata[53:6];
  assign in_py    = s_axis_tdata[101:54];
  assign in_time  = s_axis_tdata[163:102];
  assign in_parx  = s_axis_tdata[211:164];
  assign in_pary  = s_axis_tdata[259:212];

  // Stage A: clock sum (63 bits) and then mod period, one restoring step per stage.
  // Write items ride along with their point in the coordinate slots.
  localparam int unsigned SA = TW + 1;
  logic          a_v   [SA+1];
  logic          a_w   [SA+1];
  logic [IW-1:0] a_wi  [SA+1];
  logic          a_hp  [SA+1];
  logic [TW:0]   a_num [SA+1];
  logic [TW:0]   a_rem [SA+1];
  logic [CW-1:0] a_x   [SA+1];
  logic [CW-1:0] a_y   [SA+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SA; i++) begin
        a_v[i] <= 1'b0;
        a_w[i] <= 1'b0;
      end
    end else if (adv) begin
      a_v[0] <= in_query;
      a_w[0] <= in_write;
      for (int i = 1; i <= SA; i++) begin
        a_v[i] <= a_v[i-1];
        a_w[i] <= a_w[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hp[0]  <= has_parent;
      a_num[0] <= {1'b0, in_time} + {1'b0, clock_offset};
      a_rem[0] <= '0;
      a_wi[0]  <= IW'(in_index);
      a_x[0]   <= (s_axis_tuser == poi_pkg::REQ_QUERY) ? in_parx : in_px;
      a_y[0]   <= (s_axis_tuser == poi_pkg::REQ_QUERY) ? in_pary : in_py;
      for (int i = 1; i <= SA; i++) begin
        logic [TW+1:0] t;
        t = {a_rem[i-1], a_num[i-1][TW]};
        a_num[i] <= {a_num[i-1][TW-1:0], 1'b0};
        a_rem[i] <= (t >= {2'b0, per}) ? (TW+1)'(t - {2'b0, per}) : t[TW:0];
        a_hp[i]  <= a_hp[i-1];
        a_wi[i]  <= a_wi[i-1];
        a_x[i]   <= a_x[i-1];
        a_y[i]   <= a_y[i-1];
      end
    end
  end

  // Stage B: clock / segment; the quotient is reduced modulo POINTS as it is formed.
  localparam int unsigned SB = TW;
  logic          b_v   [SB+1];
  logic          b_w   [SB+1];
  logic [IW-1:0] b_wi  [SB+1];
  logic          b_hp  [SB+1];
  logic [TW-1:0] b_num [SB+1];
  logic [TW-1:0] b_rem [SB+1];
  logic [IW-1:0] b_q   [SB+1];
  logic [CW-1:0] b_x   [SB+1];
  logic [CW-1:0] b_y   [SB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SB; i++) begin
        b_v[i] <= 1'b0;
        b_w[i] <= 1'b0;
      end
    end else if (adv) begin
      b_v[0] <= a_v[SA];
      b_w[0] <= a_w[SA];
      for (int i = 1; i <= SB; i++) begin
        b_v[i] <= b_v[i-1];
        b_w[i] <= b_w[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_hp[0]  <= a_hp[SA];
      b_num[0] <= a_rem[SA][TW-1:0];
      b_rem[0] <= '0;
      b_q[0]   <= '0;
      b_wi[0]  <= a_wi[SA];
      b_x[0]   <= a_x[SA];
      b_y[0]   <= a_y[SA];
      for (int i = 1; i <= SB; i++) begin
        logic [TW:0] t;
        logic        ge;
        logic [IW:0] qn;
        t  = {b_rem[i-1], b_num[i-1][TW-1]};
        ge = (t >= {1'b0, seg});
        qn = {b_q[i-1], ge};
        b_num[i] <= {b_num[i-1][TW-2:0], 1'b0};
        b_rem[i] <= ge ? TW'(t - {1'b0, seg}) : t[TW-1:0];
        b_q[i]   <= (32'(qn) >= POINTS) ? IW'(qn - (IW+1)'(POINTS)) : qn[IW-1:0];
        b_hp[i]  <= b_hp[i-1];
        b_wi[i]  <= b_wi[i-1];
        b_x[i]   <= b_x[i-1];
        b_y[i]   <= b_y[i-1];
      end
    end
  end

  // Table RAMs: reads for both neighbouring points, two read ports via duplicate copies.
  // Writes land at the end of stage B, so each query sees the table in beat order.
  logic [IW-1:0] idx, nidx;
  logic [CW-1:0] cx, cy, nx, ny;
  assign idx  = b_q[SB];
  assign nidx = (32'(idx) == POINTS - 1) ? '0 : IW'(idx + 1'b1);

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  assign ram_we    = adv && b_w[SB];
  assign ram_waddr = b_wi[SB];

  logic [IW-1:0] ram_raddr_c, ram_raddr_n;
  logic [IW-1:0] hold_c, hold_n;
  // Read address holds during a stall so the registered data stays valid.
  always_ff @(posedge clk) begin
    if (adv) begin
      hold_c <= idx;
      hold_n <= nidx;
    end
  end
  assign ram_raddr_c = adv ? idx : hold_c;
  assign ram_raddr_n = adv ? nidx : hold_n;

  poi_ram #(.WIDTH(CW), .DEPTH(POINTS)) u_xc (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(b_x[SB]), .raddr(ram_raddr_c), .rdata(cx));
  poi_ram #(.WIDTH(CW), .DEPTH(POINTS)) u_xn (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(b_x[SB]), .raddr(ram_raddr_n), .rdata(nx));
  poi_ram #(.WIDTH(CW), .DEPTH(POINTS)) u_yc (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(b_y[SB]), .raddr(ram_raddr_c), .rdata(cy));
  poi_ram #(.WIDTH(CW), .DEPTH(POINTS)) u_yn (.clk, .we(ram_we), .waddr(ram_waddr),
    .wdata(b_y[SB]), .raddr(ram_raddr_n), .rdata(ny));

  // Stage C: RAM read cycle, carry side data alongside.
  logic          c_v, c_hp;
  logic [TW-1:0] c_rem;
  logic [CW-1:0] c_px, c_py;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= b_v[SB];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_hp  <= b_hp[SB];
      c_rem <= b_rem[SB];
      c_px  <= b_x[SB];
      c_py  <= b_y[SB];
    end
  end

  // Stage D: differences, magnitudes and signs.
  logic          d_v, d_hp, d_sx, d_sy;
  logic [TW-1:0] d_rem;
  logic [CW:0]   d_mx, d_my;
  logic [CW-1:0] d_cx, d_cy, d_px, d_py;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= c_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [CW:0] dx, dy;
      dx = $signed({nx[CW-1], nx}) - $signed({cx[CW-1], cx});
      dy = $signed({ny[CW-1], ny}) - $signed({cy[CW-1], cy});
      d_sx  <= dx[CW];
      d_sy  <= dy[CW];
      d_mx  <= dx[CW] ? (CW+1)'(-dx) : dx;
      d_my  <= dy[CW] ? (CW+1)'(-dy) : dy;
      d_hp  <= c_hp;
      d_rem <= c_rem;
      d_cx  <= cx;
      d_cy  <= cy;
      d_px  <= c_px;
      d_py  <= c_py;
    end
  end

  // Stage E/F: 49 x 62 product built from four partial products of at most 25 x 31 bits.
  logic          e_v, e_hp, e_sx, e_sy;
  logic [55:0]   e_xll, e_xlh, e_xhl, e_xhh, e_yll, e_ylh, e_yhl, e_yhh;
  logic [CW-1:0] e_cx, e_cy, e_px, e_py;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_xll <= 56'(d_mx[24:0]) * 56'(d_rem[30:0]);
      e_xlh <= 56'(d_mx[24:0]) * 56'(d_rem[61:31]);
      e_xhl <= 56'(d_mx[48:25]) * 56'(d_rem[30:0]);
      e_xhh <= 56'(d_mx[48:25]) * 56'(d_rem[61:31]);
      e_yll <= 56'(d_my[24:0]) * 56'(d_rem[30:0]);
      e_ylh <= 56'(d_my[24:0]) * 56'(d_rem[61:31]);
      e_yhl <= 56'(d_my[48:25]) * 56'(d_rem[30:0]);
      e_yhh <= 56'(d_my[48:25]) * 56'(d_rem[61:31]);
      e_hp <= d_hp; e_sx <= d_sx; e_sy <= d_sy;
      e_cx <= d_cx; e_cy <= d_cy; e_px <= d_px; e_py <= d_py;
    end
  end

  logic          f_v, f_hp, f_sx, f_sy;
  logic [PW-1:0] f_prx, f_pry;
  logic [CW-1:0] f_cx, f_cy, f_px, f_py;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_prx <= PW'(e_xll) + (PW'(e_xlh) << 31) + (PW'(e_xhl) << 25) + (PW'(e_xhh) << 56);
      f_pry <= PW'(e_yll) + (PW'(e_ylh) << 31) + (PW'(e_yhl) << 25) + (PW'(e_yhh) << 56);
      f_hp <= e_hp; f_sx <= e_sx; f_sy <= e_sy;
      f_cx <= e_cx; f_cy <= e_cy; f_px <= e_px; f_py <= e_py;
    end
  end

  // Stage G: product / segment for both axes, one quotient bit per stage.
  localparam int unsigned SG = PW;
  logic          g_v   [SG+1];
  logic          g_hp  [SG+1];
  logic          g_sx  [SG+1];
  logic          g_sy  [SG+1];
  logic [PW-1:0] g_nx  [SG+1];
  logic [PW-1:0] g_ny  [SG+1];
  logic [TW-1:0] g_rx  [SG+1];
  logic [TW-1:0] g_ry  [SG+1];
  logic [CW-1:0] g_qx  [SG+1];
  logic [CW-1:0] g_qy  [SG+1];
  logic [CW-1:0] g_cx  [SG+1];
  logic [CW-1:0] g_cy  [SG+1];
  logic [CW-1:0] g_px  [SG+1];
  logic [CW-1:0] g_py  [SG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SG; i++) g_v[i] <= 1'b0;
    end else if (adv) begin
      g_v[0] <= f_v;
      for (int i = 1; i <= SG; i++) g_v[i] <= g_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_hp[0] <= f_hp; g_sx[0] <= f_sx; g_sy[0] <= f_sy;
      g_nx[0] <= f_prx; g_ny[0] <= f_pry;
      g_rx[0] <= '0; g_ry[0] <= '0; g_qx[0] <= '0; g_qy[0] <= '0;
      g_cx[0] <= f_cx; g_cy[0] <= f_cy; g_px[0] <= f_px; g_py[0] <= f_py;
      for (int i = 1; i <= SG; i++) begin
        logic [TW:0] tx, ty;
        logic        gx, gy;
        tx = {g_rx[i-1], g_nx[i-1][PW-1]};
        ty = {g_ry[i-1], g_ny[i-1][PW-1]};
        gx = (tx >= {1'b0, seg});
        gy = (ty >= {1'b0, seg});
        g_nx[i] <= {g_nx[i-1][PW-2:0], 1'b0};
        g_ny[i] <= {g_ny[i-1][PW-2:0], 1'b0};
        g_rx[i] <= gx ? TW'(tx - {1'b0, seg}) : tx[TW-1:0];
        g_ry[i] <= gy ? TW'(ty - {1'b0, seg}) : ty[TW-1:0];
        g_qx[i] <= {g_qx[i-1][CW-2:0], gx};
        g_qy[i] <= {g_qy[i-1][CW-2:0], gy};
        g_hp[i] <= g_hp[i-1]; g_sx[i] <= g_sx[i-1]; g_sy[i] <= g_sy[i-1];
        g_cx[i] <= g_cx[i-1]; g_cy[i] <= g_cy[i-1];
        g_px[i] <= g_px[i-1]; g_py[i] <= g_py[i-1];
      end
    end
  end

  // Output register: final sums modulo 2^48, or zero when has_parent is clear.
  logic [CW-1:0] ox, oy, offx, offy;
  assign offx = g_sx[SG] ? CW'(-g_qx[SG]) : g_qx[SG];
  assign offy = g_sy[SG] ? CW'(-g_qy[SG]) : g_qy[SG];
  assign ox = g_hp[SG] ? CW'(g_cx[SG] + offx + g_px[SG]) : '0;
  assign oy = g_hp[SG] ? CW'(g_cy[SG] + offy + g_py[SG]) : '0;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= g_v[SG];
  end
  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {oy, ox};
  end

  // Checks on the pipeline control.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready disagrees with output stage");
  a_nowr: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tuser == poi_pkg::REQ_WRITE |=> !a_v[0])
    else $error("write item entered query pipeline");

endmodule

// ===== design/poi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module poi_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
